>>> sv/assert_macros.svh
// assertion macros shared by the battery voltage meter rtl
// no dependencies; ASSERT_OFF removes every check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// clocked check, quiet while reset is applied
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds during reset
`define ASSERT_ALW(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

>>> sv/bvm_pkg.sv
// shared types, widths, constants and the microcode rom of the battery voltage meter
// no dependencies
package bvm_pkg;

	// field and datapath widths
	localparam int FILTER_FRAC_BITS = 16;
	localparam int SAMPLE_W  = 12;
	localparam int GAIN_W    = 16;
	localparam int REG8_W    = 8;
	localparam int VOLT_W    = 16;
	localparam int ACC_W     = SAMPLE_W + FILTER_FRAC_BITS;
	localparam int LO_W      = ACC_W / 2;
	localparam int HI_W      = ACC_W - LO_W;
	localparam int FULL_W    = GAIN_W + ACC_W;
	localparam int SCALED_W  = SAMPLE_W + REG8_W;
	localparam int NUM_W     = 29;
	localparam int DEN_W     = SAMPLE_W + REG8_W;
	localparam int CNT_W     = $clog2(NUM_W);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int STEP_W    = 4;

	// arithmetic constants: 3300 / 10 folded into one factor, 4095 * 5 rounding term
	localparam logic [SAMPLE_W-1:0] ADC_FULL  = 12'hFFF;
	localparam logic [8:0]          K_REF     = 9'd330;
	localparam logic [14:0]         ROUND_ADD = 15'd20475;
	localparam logic [CNT_W-1:0]    DIV_LAST  = CNT_W'(NUM_W - 1);
	localparam logic [ACC_W-1:0]    ACC_MAX   = {ADC_FULL, {FILTER_FRAC_BITS{1'b0}}};

	// register reset values
	localparam logic [REG8_W-1:0] SCALE_RST = 8'd110;
	localparam logic [REG8_W-1:0] DIV_RST   = 8'd10;
	localparam logic [REG8_W-1:0] MULT_RST  = 8'd1;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd6554;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE = 2'd0,
		CFG_DIV   = 2'd1,
		CFG_MULT  = 2'd2,
		CFG_GAIN  = 2'd3
	} cfg_idx_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_DIFF, OP_MLO, OP_MHI, OP_ACC,
		OP_SCL, OP_NUM, OP_DIV, OP_DIV2_LD, OP_SAT, OP_EMIT
	} dp_op_t;

	// sequencer jump kinds
	typedef enum logic [2:0] {
		JMP_NEXT, JMP_WAIT_IN, JMP_LOOP, JMP_PASS, JMP_WAIT_OUT, JMP_ALWAYS
	} jmp_t;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t ST_WAIT  = 4'd0;
	localparam step_t ST_DIFF  = 4'd1;
	localparam step_t ST_MLO   = 4'd2;
	localparam step_t ST_MHI   = 4'd3;
	localparam step_t ST_ACC   = 4'd4;
	localparam step_t ST_SCL   = 4'd5;
	localparam step_t ST_NUM   = 4'd6;
	localparam step_t ST_DIV1  = 4'd7;
	localparam step_t ST_DIV2L = 4'd8;
	localparam step_t ST_DIV2  = 4'd9;
	localparam step_t ST_SAT   = 4'd10;
	localparam step_t ST_EMIT  = 4'd11;

	// one control word
	typedef struct packed {
		dp_op_t op;
		jmp_t   jmp;
		logic   load_cnt;
		step_t  target;
	} ctrl_t;

	// status fed back to the sequencer
	typedef struct packed {
		logic in_xfer;
		logic out_busy;
	} seq_stat_t;

	// microcode rom
	function automatic ctrl_t ucode_rom(input step_t step);
		ctrl_t w;
		w = '{op: OP_NOP, jmp: JMP_NEXT, load_cnt: 1'b0, target: ST_WAIT};
		unique case (step)
			ST_WAIT:  begin w.op = OP_LOAD;    w.jmp = JMP_WAIT_IN; end
			ST_DIFF:  w.op = OP_DIFF;
			ST_MLO:   w.op = OP_MLO;
			ST_MHI:   w.op = OP_MHI;
			ST_ACC:   w.op = OP_ACC;
			ST_SCL:   w.op = OP_SCL;
			ST_NUM:   begin w.op = OP_NUM;     w.load_cnt = 1'b1; end
			ST_DIV1:  begin w.op = OP_DIV;     w.jmp = JMP_LOOP; end
			ST_DIV2L: begin w.op = OP_DIV2_LD; w.load_cnt = 1'b1; end
			ST_DIV2:  begin w.op = OP_DIV;     w.jmp = JMP_LOOP; end
			ST_SAT:   begin w.op = OP_SAT;     w.jmp = JMP_PASS; w.target = ST_SCL; end
			ST_EMIT:  begin w.op = OP_EMIT;    w.jmp = JMP_WAIT_OUT; w.target = ST_WAIT; end
			default:  begin w.jmp = JMP_ALWAYS; w.target = ST_WAIT; end
		endcase
		return w;
	endfunction

endpackage

>>> sv/bvm_if.sv
// channel interfaces of the battery voltage meter: sample in, result out, config write
// depends on bvm_pkg
interface bvm_in_if;
	logic                          valid;
	logic                          ready;
	logic [bvm_pkg::SAMPLE_W-1:0]  adc_sample;
	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface bvm_out_if;
	logic                        valid;
	logic                        ready;
	logic [bvm_pkg::VOLT_W-1:0]  filtered_voltage;
	logic [bvm_pkg::VOLT_W-1:0]  raw_voltage;
	modport source (output valid, output filtered_voltage, output raw_voltage, input ready);
	modport sink   (input valid, input filtered_voltage, input raw_voltage, output ready);
endinterface

interface bvm_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bvm_pkg::CFG_IDX_W-1:0]  index;
	logic [bvm_pkg::CFG_DAT_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/bvm_seq.sv
// microcode sequencer: step counter, loop counter, pass flag and rom lookup
// depends on bvm_pkg and assert_macros.svh
`include "assert_macros.svh"

module bvm_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  bvm_pkg::seq_stat_t  stat,
	output bvm_pkg::ctrl_t      ctrl,
	output logic                pass
);
	import bvm_pkg::*;

	step_t            step_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pass_q;

	// control word of the current step
	assign ctrl = ucode_rom(step_q);
	assign pass = pass_q;

	// step, loop and pass update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
			cnt_q  <= '0;
			pass_q <= 1'b0;
		end else begin
			if (ctrl.load_cnt) begin
				cnt_q <= DIV_LAST;
			end
			unique case (ctrl.jmp)
				JMP_NEXT: step_q <= step_q + 1'b1;
				JMP_WAIT_IN: begin
					if (stat.in_xfer) begin
						step_q <= step_q + 1'b1;
					end
				end
				JMP_LOOP: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				JMP_PASS: begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						step_q <= ctrl.target;
					end else begin
						pass_q <= 1'b0;
						step_q <= step_q + 1'b1;
					end
				end
				JMP_WAIT_OUT: begin
					if (!stat.out_busy) begin
						step_q <= ctrl.target;
					end
				end
				default: step_q <= ctrl.target;
			endcase
		end
	end

	// program stays inside its listing
	`ASSERT_RST(a_step_range, clk, arst_n, step_q <= ST_EMIT, "step counter left the program")
	// a pending loop count only exists inside a division loop
	`ASSERT_RST(a_cnt_loop, clk, arst_n, (cnt_q != '0) |-> (ctrl.jmp == JMP_LOOP), "loop count outside loop")
	// second pass only covers the conversion steps
	`ASSERT_RST(a_pass_span, clk, arst_n, pass_q |-> (step_q >= ST_SCL && step_q <= ST_SAT), "pass flag outside conversion")

endmodule

>>> sv/bvm_dp.sv
// datapath: low-pass filter, centivolt scaling, shared bit-serial divider, output register
// depends on bvm_pkg and assert_macros.svh
`include "assert_macros.svh"

module bvm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvm_pkg::ctrl_t                ctrl,
	input  logic                          pass,
	input  logic                          in_xfer,
	input  logic [bvm_pkg::SAMPLE_W-1:0]  adc_sample,
	input  logic [bvm_pkg::REG8_W-1:0]    scale,
	input  logic [bvm_pkg::REG8_W-1:0]    div,
	input  logic [bvm_pkg::REG8_W-1:0]    mult,
	input  logic [bvm_pkg::GAIN_W-1:0]    gain,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [bvm_pkg::VOLT_W-1:0]    filtered_voltage,
	output logic [bvm_pkg::VOLT_W-1:0]    raw_voltage,
	output logic                          out_busy
);
	import bvm_pkg::*;

	logic [SAMPLE_W-1:0]     sample_q;
	logic                    neg_q;
	logic [ACC_W-1:0]        mag_q;
	logic [GAIN_W+LO_W-1:0]  plo_q;
	logic [GAIN_W+HI_W-1:0]  phi_q;
	logic [ACC_W-1:0]        acc_q;
	logic [SCALED_W-1:0]     t_q;
	logic [NUM_W-1:0]        quo_q;
	logic [DEN_W-1:0]        rem_q;
	logic [DEN_W-1:0]        dvs_q;
	logic [VOLT_W-1:0]       filt_q;
	logic [VOLT_W-1:0]       raw_q;
	logic [VOLT_W-1:0]       outf_q;
	logic [VOLT_W-1:0]       outr_q;
	logic                    out_valid_q;

	logic [ACC_W-1:0]        x_c;
	logic [FULL_W-1:0]       full_c;
	logic [ACC_W-1:0]        step_c;
	logic [SAMPLE_W-1:0]     s_c;
	logic [NUM_W-1:0]        num_c;
	logic [DEN_W-1:0]        den_c;
	logic [DEN_W:0]          part_c;
	logic [DEN_W:0]          diff_c;
	logic                    ge_c;
	logic [VOLT_W-1:0]       sat_c;
	logic                    emit_c;

	// filter arithmetic
	assign x_c    = {sample_q, {FILTER_FRAC_BITS{1'b0}}};
	assign full_c = FULL_W'({phi_q, {LO_W{1'b0}}}) + FULL_W'(plo_q);
	assign step_c = full_c[FULL_W-1:GAIN_W];

	// conversion operand: filtered first, raw on the second pass
	assign s_c   = pass ? sample_q : acc_q[ACC_W-1:FILTER_FRAC_BITS];
	assign num_c = NUM_W'(t_q) * NUM_W'(K_REF) + NUM_W'(ROUND_ADD);
	assign den_c = DEN_W'({div, {SAMPLE_W{1'b0}}}) - DEN_W'(div);

	// one restoring division step
	assign part_c = {rem_q, quo_q[NUM_W-1]};
	assign ge_c   = part_c >= {1'b0, dvs_q};
	assign diff_c = part_c - {1'b0, dvs_q};

	// saturate the quotient
	assign sat_c = (quo_q[NUM_W-1:VOLT_W] != '0) ? {VOLT_W{1'b1}} : quo_q[VOLT_W-1:0];

	// output register handshake
	assign out_busy = out_valid_q & ~out_ready;
	assign emit_c   = (ctrl.op == OP_EMIT) & ~out_busy;

	// working registers
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (in_xfer) begin
					sample_q <= adc_sample;
				end
			end
			OP_DIFF: begin
				neg_q <= x_c < acc_q;
				mag_q <= (x_c < acc_q) ? (acc_q - x_c) : (x_c - acc_q);
			end
			OP_MLO:     plo_q <= (GAIN_W+LO_W)'(gain) * (GAIN_W+LO_W)'(mag_q[LO_W-1:0]);
			OP_MHI:     phi_q <= (GAIN_W+HI_W)'(gain) * (GAIN_W+HI_W)'(mag_q[ACC_W-1:LO_W]);
			OP_SCL:     t_q <= SCALED_W'(s_c) * SCALED_W'(scale);
			OP_NUM: begin
				quo_q <= num_c;
				rem_q <= '0;
				dvs_q <= den_c;
			end
			OP_DIV: begin
				quo_q <= {quo_q[NUM_W-2:0], ge_c};
				rem_q <= ge_c ? diff_c[DEN_W-1:0] : part_c[DEN_W-1:0];
			end
			OP_DIV2_LD: begin
				rem_q <= '0;
				dvs_q <= DEN_W'(mult);
			end
			OP_SAT: begin
				if (pass) begin
					raw_q <= sat_c;
				end else begin
					filt_q <= sat_c;
				end
			end
			default: ;
		endcase
		if (emit_c) begin
			outf_q <= filt_q;
			outr_q <= raw_q;
		end
	end

	// filter state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_ACC) begin
				acc_q <= neg_q ? (acc_q - step_c) : (acc_q + step_c);
			end
			if (emit_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign filtered_voltage = outf_q;
	assign raw_voltage      = outr_q;

	// filter never overshoots full scale
	`ASSERT_RST(a_acc_range, clk, arst_n, acc_q <= ACC_MAX, "filter accumulator above full scale")
	// a waiting result stays offered
	`ASSERT_RST(a_out_keep, clk, arst_n, out_busy |=> out_valid_q, "held result dropped")
	// a waiting result keeps its payload
	`ASSERT_RST(a_out_hold, clk, arst_n, out_busy |=> $stable({outf_q, outr_q}), "held result changed")

endmodule

>>> sv/battery_voltage_adc_meter.sv
// battery voltage meter: one 12-bit sample in, filtered and raw centivolts out
// the shared one-bit-per-cycle divider does four 29-step divisions per result;
// a new sample is taken only once the previous result has entered the output register
// a finished result waits in the output register while the next sample is taken
// async active-low reset: sequencer idle, filter zero, registers 110 / 10 / 1 / 6554
// depends on bvm_pkg, bvm_if, bvm_seq, bvm_dp

module battery_voltage_adc_meter (
	input  logic        clk,
	input  logic        arst_n,
	bvm_in_if.sink      adc_in,
	bvm_out_if.source   volt_out,
	bvm_cfg_if.sink     cfg_wr
);
	import bvm_pkg::*;

	logic [REG8_W-1:0] scale_q;
	logic [REG8_W-1:0] div_q;
	logic [REG8_W-1:0] mult_q;
	logic [GAIN_W-1:0] gain_q;

	ctrl_t     ctrl;
	seq_stat_t stat;
	logic      pass;
	logic      in_xfer;
	logic      out_busy;

	// input transfer only in the wait step
	assign adc_in.ready  = (ctrl.jmp == JMP_WAIT_IN);
	assign in_xfer       = adc_in.valid & adc_in.ready;
	assign stat.in_xfer  = in_xfer;
	assign stat.out_busy = out_busy;

	// configuration registers
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RST;
			div_q   <= DIV_RST;
			mult_q  <= MULT_RST;
			gain_q  <= GAIN_RST;
		end else if (cfg_wr.valid) begin
			unique case (cfg_idx_t'(cfg_wr.index))
				CFG_SCALE: scale_q <= cfg_wr.data[REG8_W-1:0];
				CFG_DIV:   div_q   <= cfg_wr.data[REG8_W-1:0];
				CFG_MULT:  mult_q  <= cfg_wr.data[REG8_W-1:0];
				CFG_GAIN:  gain_q  <= cfg_wr.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	bvm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl),
		.pass   (pass)
	);

	// datapath
	bvm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.pass             (pass),
		.in_xfer          (in_xfer),
		.adc_sample       (adc_in.adc_sample),
		.scale            (scale_q),
		.div              (div_q),
		.mult             (mult_q),
		.gain             (gain_q),
		.out_ready        (volt_out.ready),
		.out_valid        (volt_out.valid),
		.filtered_voltage (volt_out.filtered_voltage),
		.raw_voltage      (volt_out.raw_voltage),
		.out_busy         (out_busy)
	);

endmodule

>>> dv/meter_check.sv
// result checker for the battery voltage meter: mirrors register writes, predicts
// the filtered and raw centivolt readings of every sample transfer and compares them
// depends on bvm_pkg and bvm_if
module meter_check (
	input  logic clk,
	input  logic arst_n,
	bvm_in_if    in_ch,
	bvm_out_if   out_ch,
	bvm_cfg_if   cfg_ch,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import bvm_pkg::*;

	localparam longint unsigned FULL_SCALE = 4095;
	localparam longint unsigned VREF_MV    = 3300;
	localparam longint unsigned ROUNDING   = FULL_SCALE * 5;
	localparam longint unsigned VOLT_MAX   = 65535;
	localparam int              REPORT_MAX = 10;

	typedef struct packed {
		logic [VOLT_W-1:0] filtered;
		logic [VOLT_W-1:0] raw;
	} reading_t;

	reading_t          reading_q[$];
	logic [REG8_W-1:0] scale_r;
	logic [REG8_W-1:0] div_r;
	logic [REG8_W-1:0] mult_r;
	logic [GAIN_W-1:0] gain_r;
	logic [ACC_W-1:0]  acc_r;
	int                err_total = 0;
	int                result_cnt = 0;

	// sample value to saturated centivolts under the current register settings
	function automatic logic [VOLT_W-1:0] centivolts(input logic [SAMPLE_W-1:0] s);
		longint unsigned num, den, q;
		num = s;
		num = num * scale_r * VREF_MV / 10 + ROUNDING;
		den = FULL_SCALE * div_r;
		if (den == 0 || mult_r == 0)
			return '1;
		q = (num / den) / mult_r;
		return (q > VOLT_MAX) ? '1 : q[VOLT_W-1:0];
	endfunction

	// one low-pass step toward the new sample, step truncated toward zero
	function automatic logic [ACC_W-1:0] filter_update(input logic [SAMPLE_W-1:0] s);
		logic [ACC_W-1:0] target;
		longint unsigned  delta, step;
		target = {s, {FILTER_FRAC_BITS{1'b0}}};
		if (target >= acc_r) begin
			delta = target - acc_r;
			step = (gain_r * delta) >> GAIN_W;
			return acc_r + ACC_W'(step);
		end
		delta = acc_r - target;
		step = (gain_r * delta) >> GAIN_W;
		return acc_r - ACC_W'(step);
	endfunction

	task automatic flag_error(input string msg);
		err_total++;
		if (err_total <= REPORT_MAX)
			$display("check: %s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			scale_r = SCALE_RST;
			div_r   = DIV_RST;
			mult_r  = MULT_RST;
			gain_r  = GAIN_RST;
			acc_r   = '0;
			reading_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (out_ch.valid && out_ch.ready) begin
				result_cnt++;
				if (reading_q.size() == 0) begin
					flag_error($sformatf("result %0d with nothing predicted: filtered %0d raw %0d",
						result_cnt, out_ch.filtered_voltage, out_ch.raw_voltage));
				end else begin
					want = reading_q.pop_front();
					if (out_ch.filtered_voltage !== want.filtered)
						flag_error($sformatf("result %0d filtered_voltage expected %0d got %0d",
							result_cnt, want.filtered, out_ch.filtered_voltage));
					if (out_ch.raw_voltage !== want.raw)
						flag_error($sformatf("result %0d raw_voltage expected %0d got %0d",
							result_cnt, want.raw, out_ch.raw_voltage));
				end
			end
			// register write transfer, 8-bit registers keep the low byte
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_idx_t'(cfg_ch.index))
					CFG_SCALE: scale_r = cfg_ch.data[REG8_W-1:0];
					CFG_DIV:   div_r   = cfg_ch.data[REG8_W-1:0];
					CFG_MULT:  mult_r  = cfg_ch.data[REG8_W-1:0];
					CFG_GAIN:  gain_r  = cfg_ch.data[GAIN_W-1:0];
					default:   ;
				endcase
			end
			// sample transfer: advance the filter and queue the reading
			if (in_ch.valid && in_ch.ready) begin
				acc_r = filter_update(in_ch.adc_sample);
				want.filtered = centivolts(acc_r[ACC_W-1 -: SAMPLE_W]);
				want.raw      = centivolts(in_ch.adc_sample);
				reading_q.push_back(want);
			end
			mismatches  <= err_total;
			outstanding <= reading_q.size();
		end
	end

endmodule

>>> dv/tb.sv
// testbench top for the battery voltage meter: clock, reset, sample and register
// stimulus, result stalls, watchdog and verdict; checking lives in meter_check
// depends on bvm_pkg, bvm_if, meter_check and battery_voltage_adc_meter
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bvm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 1200;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 160;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 161;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles = 0;
	bit   burst_in = 1'b0;
	bit   burst_out = 1'b0;
	bit   hold_out = 1'b0;
	logic [SAMPLE_W-1:0] last_sample = '0;

	bvm_in_if  adc_in();
	bvm_out_if volt_out();
	bvm_cfg_if cfg_wr();

	battery_voltage_adc_meter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.adc_in   (adc_in),
		.volt_out (volt_out),
		.cfg_wr   (cfg_wr)
	);

	meter_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (adc_in),
		.out_ch      (volt_out),
		.cfg_ch      (cfg_wr),
		.mismatches  (fail_count),
		.outstanding (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((adc_in.valid && adc_in.ready) || (volt_out.valid && volt_out.ready) ||
				(cfg_wr.valid && cfg_wr.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_out) begin
				volt_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end
			stall = burst_out ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				volt_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			volt_out.ready <= 1'b1;
			do @(posedge clk); while (!volt_out.valid);
		end
	end

	// one sample transfer after a random gap; valid stays up for back-to-back items
	task automatic put_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = burst_in ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			adc_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		adc_in.valid      <= 1'b1;
		adc_in.adc_sample <= s;
		do @(posedge clk); while (!adc_in.ready);
		last_sample = s;
	endtask

	// stop offering and wait for every predicted reading to come back
	task automatic wait_idle();
		adc_in.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data  <= value;
		do @(posedge clk); while (!cfg_wr.ready);
	endtask

	// all four registers, junk in the unused upper byte of the 8-bit ones
	task automatic reconfigure(input logic [REG8_W-1:0] sc, input logic [REG8_W-1:0] dv,
		input logic [REG8_W-1:0] ml, input logic [GAIN_W-1:0] gn);
		logic [7:0] junk;
		wait_idle();
		junk = 8'($urandom);
		put_reg(CFG_SCALE, {junk, sc});
		junk = 8'($urandom);
		put_reg(CFG_DIV, {junk, dv});
		junk = 8'($urandom);
		put_reg(CFG_MULT, {junk, ml});
		put_reg(CFG_GAIN, gn);
		cfg_wr.valid <= 1'b0;
	endtask

	task automatic random_setup();
		logic [REG8_W-1:0] sc, dv, ml;
		logic [GAIN_W-1:0] gn;
		case ($urandom_range(0, 9))
			0:       sc = '0;
			1:       sc = '1;
			default: sc = REG8_W'($urandom_range(1, 254));
		endcase
		case ($urandom_range(0, 11))
			0:       dv = '0;
			1:       dv = 8'd1;
			2:       dv = '1;
			default: dv = REG8_W'($urandom_range(1, 255));
		endcase
		case ($urandom_range(0, 11)) inside
			0:       ml = '0;
			[1:3]:   ml = 8'd1;
			4:       ml = '1;
			default: ml = REG8_W'($urandom_range(1, 32));
		endcase
		case ($urandom_range(0, 9))
			0:       gn = '0;
			1:       gn = '1;
			2:       gn = 16'd1;
			default: gn = GAIN_W'($urandom);
		endcase
		reconfigure(sc, dv, ml, gn);
	endtask

	// mostly random samples, with rails, repeats and small steps so the filter settles
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] s;
		case ($urandom_range(0, 9)) inside
			0:       s = '0;
			1:       s = '1;
			[2:3]:   s = last_sample;
			4:       s = last_sample ^ SAMPLE_W'($urandom_range(0, 15));
			default: s = SAMPLE_W'($urandom);
		endcase
		return s;
	endfunction

	initial begin
		arst_n            = 1'b0;
		adc_in.valid      = 1'b0;
		adc_in.adc_sample = '0;
		volt_out.ready    = 1'b0;
		cfg_wr.valid      = 1'b0;
		cfg_wr.index      = CFG_SCALE;
		cfg_wr.data       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: rails, alternating bits, filter rising and falling
		put_sample(12'd0);    put_sample(12'hFFF);  put_sample(12'hFFF);
		put_sample(12'hFFF);  put_sample(12'd0);    put_sample(12'hAAA);
		put_sample(12'h555);  put_sample(12'd1);    put_sample(12'hFFE);
		put_sample(12'h800);
		// full scale, unit divider, largest gain: saturation
		reconfigure('1, 8'd1, 8'd1, '1);
		put_sample(12'hFFF);  put_sample(12'd0);    put_sample(12'hFFF);
		// zero divider
		reconfigure(8'd110, '0, 8'd1, GAIN_RST);
		put_sample(12'd100);  put_sample(12'd0);
		// zero multiplier
		reconfigure(8'd110, 8'd1, '0, GAIN_RST);
		put_sample(12'd5);
		// zero scale, largest multiplier
		reconfigure('0, 8'd10, '1, GAIN_RST);
		put_sample(12'hFFF);
		// zero gain holds the filter
		reconfigure(8'd110, 8'd10, 8'd1, '0);
		put_sample(12'd3000); put_sample(12'd10);

		// random phases under random settings
		for (int p = 0; p < PHASES; p++) begin
			random_setup();
			burst_in  = ($urandom_range(0, 3) == 0);
			burst_out = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 20)
					hold_out = 1'b1;
				if (p == 5 && i == 80)
					wait_idle();
				put_sample(pick_sample());
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
